/* src/mrect_pkg.sv */
// Package for the rectangle merge block: field widths, the stored box record,
// the join-unit result record and the controller state type.
// No dependencies; every other file in src uses it by scoped names.
package mrect_pkg;

   localparam int COORD_W  = 14;
   localparam int SIZE_W   = 15;
   localparam int EDGE_W   = 15;
   localparam int MARGIN_W = 12;
   localparam int OVL_W    = 17;

   localparam logic [SIZE_W-1:0] SIZE_LIMIT = 15'd16384;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [SIZE_W-1:0]  w;
      logic [SIZE_W-1:0]  h;
   } box_type;

   typedef struct packed {
      logic    hit;
      box_type box;
   } join_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_FETCH_A,
      ST_LATCH_A,
      ST_SCAN,
      ST_EMIT_SEEK,
      ST_EMIT_LOAD
   } state_type;

   // Clamp a size to the image limit.
   function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
      sat_size = (v > SIZE_LIMIT) ? SIZE_LIMIT : v;
   endfunction

endpackage

/* src/mrect_ifs.sv */
// Valid/ready channel interfaces of the rectangle merge block: input rectangles,
// surviving rectangles and the margin register write channel.
// Depends on mrect_pkg for the field widths.
interface mrect_req_if;
   logic                          valid;
   logic                          ready;
   logic [mrect_pkg::COORD_W-1:0] in_x;
   logic [mrect_pkg::COORD_W-1:0] in_y;
   logic [mrect_pkg::SIZE_W-1:0]  in_width;
   logic [mrect_pkg::SIZE_W-1:0]  in_height;
   logic                          in_last;

   modport source (output valid, in_x, in_y, in_width, in_height, in_last, input ready);
   modport sink   (input valid, in_x, in_y, in_width, in_height, in_last, output ready);
endinterface

interface mrect_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mrect_pkg::COORD_W-1:0] out_x;
   logic [mrect_pkg::COORD_W-1:0] out_y;
   logic [mrect_pkg::SIZE_W-1:0]  out_width;
   logic [mrect_pkg::SIZE_W-1:0]  out_height;
   logic                          out_last;

   modport source (output valid, out_x, out_y, out_width, out_height, out_last,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_width, out_height, out_last,
                   output ready);
endinterface

interface mrect_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mrect_pkg::MARGIN_W-1:0] merge_margin;

   modport source (output valid, merge_margin, input ready);
   modport sink   (input valid, merge_margin, output ready);
endinterface

/* src/merge_overlapping_rects_core.sv */
// Top level of the rectangle merge block: batch collection, greedy pairwise
// merge over the rectangle store, and emission of the surviving rectangles.
// Depends on mrect_pkg, mrect_ifs (channel interfaces), mrect_mem and mrect_join.

// The block collects a batch of rectangles, one per input transfer and one
// per cycle, into a single-port-read store of MAX_RECTS entries; a rectangle
// that arrives once the store is full is dropped. The transfer with in_last
// set closes the batch and starts the merge, during which no input transfer
// is taken. The merge holds box i in a register and streams boxes j = i+1 ..
// n-1 from the store, one pair per cycle, writing the union back to entry j
// whenever the pair joins. For each box i the merge first reads box i from
// the store and latches it in the register, then scans; the one read port
// of the store serves all of these reads. Emission then skips each absorbed
// entry and, for each survivor, reads it from the store and then loads it
// into the result register, holding back while that register is not taken. The
// result register decouples the output side, so the first rectangle of the
// next batch can be taken while the final survivor still waits for its
// transfer. Widths and heights are clamped to 16384 both on entry and after
// each union. The margin register can be written at any time the block is
// idle and takes effect for the next merge; it needs no clearing pass, as
// only entries written in the current batch are ever read.
module merge_overlapping_rects_core #(
   parameter int MAX_RECTS = 32
) (
   input logic        clock,
   input logic        reset,
   mrect_req_if.sink   req_chan,
   mrect_rsp_if.source rsp_chan,
   mrect_csr_if.sink   csr_chan
);

   localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CNT_W = $clog2(MAX_RECTS + 1);

   // Controller state.
   mrect_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [MAX_RECTS-1:0] absorbed_ff, absorbed_in;
   mrect_pkg::box_type   box_a_ff, box_a_in;

   logic signed [mrect_pkg::MARGIN_W-1:0] margin_ff, margin_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mrect_pkg::COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [mrect_pkg::COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic [mrect_pkg::SIZE_W-1:0]  rsp_width_ff, rsp_width_in;
   logic [mrect_pkg::SIZE_W-1:0]  rsp_height_ff, rsp_height_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Store port signals.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   mrect_pkg::box_type wr_data;
   logic [IDX_W-1:0]   rd_addr;
   mrect_pkg::box_type rd_data;

   mrect_pkg::join_type join_res;

   logic             req_fire;
   logic             full;
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] last_idx;
   logic             j_at_last;
   logic             i_next_last;
   logic             emit_at_last;
   logic             rsp_free;

   mrect_mem #(
      .DEPTH  (MAX_RECTS),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mrect_join u_join (
      .box_a  (box_a_ff),
      .box_b  (rd_data),
      .margin (margin_ff),
      .result (join_res)
   );

   // The input side is open only while a batch is being collected.
   assign req_chan.ready = (state_ff == mrect_pkg::ST_COLLECT);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign full         = (count_ff == CNT_W'(MAX_RECTS));
   assign count_m1     = count_ff - CNT_W'(1);
   assign last_idx     = count_m1[IDX_W-1:0];
   assign j_at_last    = (j_ff == last_idx);
   assign i_next_last  = ((i_ff + IDX_W'(1)) == last_idx);
   assign emit_at_last = (i_ff == last_idx);
   // The result register is free in the next cycle when it is empty now or
   // its transfer completes at this edge.
   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrect_pkg::ST_COLLECT: begin
            if (req_fire && req_chan.in_last) begin
               // A batch of one box has nothing to merge.
               state_in = (count_ff != '0) ? mrect_pkg::ST_FETCH_A
                                           : mrect_pkg::ST_EMIT_SEEK;
            end
         end
         mrect_pkg::ST_FETCH_A: begin
            state_in = mrect_pkg::ST_LATCH_A;
         end
         mrect_pkg::ST_LATCH_A: begin
            state_in = mrect_pkg::ST_SCAN;
         end
         mrect_pkg::ST_SCAN: begin
            if (j_at_last) begin
               state_in = i_next_last ? mrect_pkg::ST_EMIT_SEEK : mrect_pkg::ST_FETCH_A;
            end
         end
         mrect_pkg::ST_EMIT_SEEK: begin
            if (!absorbed_ff[i_ff] && rsp_free) begin
               state_in = mrect_pkg::ST_EMIT_LOAD;
            end
         end
         mrect_pkg::ST_EMIT_LOAD: begin
            state_in = emit_at_last ? mrect_pkg::ST_COLLECT : mrect_pkg::ST_EMIT_SEEK;
         end
         default: begin
            state_in = mrect_pkg::ST_COLLECT;
         end
      endcase
   end

   // Datapath and store control.
   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      absorbed_in = absorbed_ff;
      box_a_in    = box_a_ff;
      margin_in   = csr_chan.valid ? signed'(csr_chan.merge_margin) : margin_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = join_res.box;
      rd_addr = i_ff;

      case (state_ff)
         mrect_pkg::ST_COLLECT: begin
            wr_addr   = count_ff[IDX_W-1:0];
            wr_data.x = req_chan.in_x;
            wr_data.y = req_chan.in_y;
            wr_data.w = mrect_pkg::sat_size(req_chan.in_width);
            wr_data.h = mrect_pkg::sat_size(req_chan.in_height);
            if (req_fire && !full) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            if (req_fire && req_chan.in_last) begin
               i_in = '0;
            end
         end
         mrect_pkg::ST_FETCH_A: begin
            rd_addr = i_ff;
         end
         mrect_pkg::ST_LATCH_A: begin
            box_a_in = rd_data;
            j_in     = i_ff + IDX_W'(1);
            rd_addr  = i_ff + IDX_W'(1);
         end
         mrect_pkg::ST_SCAN: begin
            // Box i lives in box_a_ff; box j arrives from the store.
            if (join_res.hit) begin
               wr_en             = 1'b1;
               wr_addr           = j_ff;
               wr_data           = join_res.box;
               box_a_in          = join_res.box;
               absorbed_in[i_ff] = 1'b1;
            end
            rd_addr = j_ff + IDX_W'(1);
            if (j_at_last) begin
               i_in = i_next_last ? '0 : (i_ff + IDX_W'(1));
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         mrect_pkg::ST_EMIT_SEEK: begin
            rd_addr = i_ff;
            if (absorbed_ff[i_ff]) begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         mrect_pkg::ST_EMIT_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_x_in      = rd_data.x;
            rsp_y_in      = rd_data.y;
            rsp_width_in  = rd_data.w;
            rsp_height_in = rd_data.h;
            // The highest box is never absorbed, so it is always the final survivor.
            rsp_last_in   = emit_at_last;
            if (emit_at_last) begin
               count_in    = '0;
               absorbed_in = '0;
               i_in        = '0;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         default: begin
            rd_addr = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrect_pkg::ST_COLLECT;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         absorbed_ff  <= '0;
         margin_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         absorbed_ff  <= absorbed_in;
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      box_a_ff      <= box_a_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_x      = rsp_x_ff;
   assign rsp_chan.out_y      = rsp_y_ff;
   assign rsp_chan.out_width  = rsp_width_ff;
   assign rsp_chan.out_height = rsp_height_ff;
   assign rsp_chan.out_last   = rsp_last_ff;

`ifndef SYNTHESIS
   // The inner index always runs above the held box.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrect_pkg::ST_SCAN) |-> (j_ff > i_ff))
      else $error("scan index not above held box index");

   // The store never holds more boxes than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("batch count exceeds store depth");

   // The highest box of a batch is never marked absorbed.
   a_last_survives: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrect_pkg::ST_EMIT_SEEK) |-> !absorbed_ff[last_idx])
      else $error("final box of batch marked absorbed");

   // Emitted sizes stay clamped to the image limit.
   a_size_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_width_ff <= mrect_pkg::SIZE_LIMIT) &&
                        (rsp_height_ff <= mrect_pkg::SIZE_LIMIT)))
      else $error("emitted size above limit");
`endif

endmodule

/* src/mrect_mem.sv */
// Rectangle store: one write port and one read port, read data registered.
// Depends on mrect_pkg for the box record.
module mrect_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  mrect_pkg::box_type wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output mrect_pkg::box_type rd_data
);

   mrect_pkg::box_type mem_ff [DEPTH];
   mrect_pkg::box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mrect_join.sv */
// Join test and union bounding box of two rectangles.
// Depends on mrect_pkg for the box and join records and the size clamp.
module mrect_join (
   input  mrect_pkg::box_type                box_a,
   input  mrect_pkg::box_type                box_b,
   input  logic signed [mrect_pkg::MARGIN_W-1:0] margin,
   output mrect_pkg::join_type               result
);

   logic [mrect_pkg::EDGE_W-1:0]       a_right, a_bottom, b_right, b_bottom;
   logic [mrect_pkg::EDGE_W-1:0]       min_right, min_bottom, max_right, max_bottom;
   logic [mrect_pkg::COORD_W-1:0]      max_x, max_y, min_x, min_y;
   logic signed [mrect_pkg::OVL_W-1:0] ovl_x, ovl_y, margin_ext;

   always_comb begin
      a_right  = mrect_pkg::EDGE_W'(box_a.x) + box_a.w;
      a_bottom = mrect_pkg::EDGE_W'(box_a.y) + box_a.h;
      b_right  = mrect_pkg::EDGE_W'(box_b.x) + box_b.w;
      b_bottom = mrect_pkg::EDGE_W'(box_b.y) + box_b.h;

      min_right  = (a_right < b_right)   ? a_right  : b_right;
      max_right  = (a_right < b_right)   ? b_right  : a_right;
      min_bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;
      max_bottom = (a_bottom < b_bottom) ? b_bottom : a_bottom;
      min_x      = (box_a.x < box_b.x)   ? box_a.x  : box_b.x;
      max_x      = (box_a.x < box_b.x)   ? box_b.x  : box_a.x;
      min_y      = (box_a.y < box_b.y)   ? box_a.y  : box_b.y;
      max_y      = (box_a.y < box_b.y)   ? box_b.y  : box_a.y;

      margin_ext = mrect_pkg::OVL_W'(margin);
      ovl_x = signed'(mrect_pkg::OVL_W'(min_right)) - signed'(mrect_pkg::OVL_W'(max_x))
              + margin_ext;
      ovl_y = signed'(mrect_pkg::OVL_W'(min_bottom)) - signed'(mrect_pkg::OVL_W'(max_y))
              + margin_ext;

      // Strictly positive overlap on both axes.
      result.hit = !ovl_x[mrect_pkg::OVL_W-1] && (ovl_x != '0) &&
                   !ovl_y[mrect_pkg::OVL_W-1] && (ovl_y != '0);
      result.box.x = min_x;
      result.box.y = min_y;
      result.box.w = mrect_pkg::sat_size(max_right - mrect_pkg::EDGE_W'(min_x));
      result.box.h = mrect_pkg::sat_size(max_bottom - mrect_pkg::EDGE_W'(min_y));
   end

endmodule

/* sim/mrect_tb_pkg.sv */
// Testbench package for the rectangle merge block: a scoreboard that predicts
// the surviving rectangles of each batch and checks the results in order.
// Depends on mrect_pkg for the field widths and the stored box record.
package mrect_tb_pkg;
   import mrect_pkg::*;

   localparam int BATCH_DEPTH = 32;
   localparam int PRINT_CAP   = 25;

   class survivor_board;
      typedef struct {
         box_type box;
         bit      last;
      } survivor_rec;

      box_type     held[BATCH_DEPTH];
      int          held_count;
      int          margin;
      survivor_rec expected_survivors[$];
      int          mismatches;
      int          survivors_seen;
      int          rects_taken;
      int          batches_closed;

      function void set_margin(logic [MARGIN_W-1:0] value);
         margin = int'($signed(value));
      endfunction

      function int pending();
         return expected_survivors.size();
      endfunction

      function int clamp_size(int v);
         return (v > int'(SIZE_LIMIT)) ? int'(SIZE_LIMIT) : v;
      endfunction

      // Boxes beyond the store depth are dropped, but a closing flag still counts.
      function void note_rect(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, bit last);
         rects_taken++;
         if (held_count < BATCH_DEPTH) begin
            held[held_count].x = x;
            held[held_count].y = y;
            held[held_count].w = SIZE_W'(clamp_size(int'(w)));
            held[held_count].h = SIZE_W'(clamp_size(int'(h)));
            held_count++;
         end
         if (last)
            run_greedy_merge();
      endfunction

      function void run_greedy_merge();
         bit          absorbed[BATCH_DEPTH];
         box_type     a;
         box_type     b;
         box_type     u;
         int          ar, ab, br, bb, ox, oy, ux, uy;
         int          last_live;
         survivor_rec rec;
         for (int i = 0; i < BATCH_DEPTH; i++)
            absorbed[i] = 1'b0;
         for (int i = 0; i < held_count; i++) begin
            for (int j = i + 1; j < held_count; j++) begin
               a  = held[i];
               b  = held[j];
               ar = int'(a.x) + int'(a.w);
               ab = int'(a.y) + int'(a.h);
               br = int'(b.x) + int'(b.w);
               bb = int'(b.y) + int'(b.h);
               ox = ((ar < br) ? ar : br) - ((a.x > b.x) ? int'(a.x) : int'(b.x)) + margin;
               oy = ((ab < bb) ? ab : bb) - ((a.y > b.y) ? int'(a.y) : int'(b.y)) + margin;
               if (ox > 0 && oy > 0) begin
                  ux  = (a.x < b.x) ? int'(a.x) : int'(b.x);
                  uy  = (a.y < b.y) ? int'(a.y) : int'(b.y);
                  u.x = COORD_W'(ux);
                  u.y = COORD_W'(uy);
                  u.w = SIZE_W'(clamp_size(((ar > br) ? ar : br) - ux));
                  u.h = SIZE_W'(clamp_size(((ab > bb) ? ab : bb) - uy));
                  held[i] = u;
                  held[j] = u;
                  absorbed[i] = 1'b1;
               end
            end
         end
         last_live = -1;
         for (int i = 0; i < held_count; i++)
            if (!absorbed[i])
               last_live = i;
         for (int i = 0; i < held_count; i++) begin
            if (!absorbed[i]) begin
               rec.box  = held[i];
               rec.last = (i == last_live);
               expected_survivors.insert(expected_survivors.size(), rec);
            end
         end
         held_count = 0;
         batches_closed++;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_survivor(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, logic last);
         survivor_rec want;
         string       diff;
         survivors_seen++;
         if (expected_survivors.size() == 0) begin
            report_mismatch($sformatf("unexpected survivor x=%0d y=%0d w=%0d h=%0d last=%0b",
                                      x, y, w, h, last));
            return;
         end
         want = expected_survivors.pop_front();
         diff = "";
         if (x !== want.box.x)
            diff = {diff, $sformatf(" x %0d/%0d", x, want.box.x)};
         if (y !== want.box.y)
            diff = {diff, $sformatf(" y %0d/%0d", y, want.box.y)};
         if (w !== want.box.w)
            diff = {diff, $sformatf(" width %0d/%0d", w, want.box.w)};
         if (h !== want.box.h)
            diff = {diff, $sformatf(" height %0d/%0d", h, want.box.h)};
         if (last !== want.last)
            diff = {diff, $sformatf(" last %0b/%0b", last, want.last)};
         if (diff != "")
            report_mismatch({"survivor got/expected:", diff});
      endtask
   endclass

endpackage

/* sim/merge_overlapping_rects_core_tb.sv */
// Testbench top for merge_overlapping_rects_core: drives rectangle batches and
// margin writes over the valid/ready channels and checks every survivor.
// Depends on mrect_pkg, the channel interfaces in mrect_ifs and mrect_tb_pkg.
module merge_overlapping_rects_core_tb;
   import mrect_pkg::*;
   import mrect_tb_pkg::*;

   // A long receiver hold-off, in cycles, used once to back the block up.
   localparam int LONG_HOLD     = 300;
   // Quiet cycles after the last survivor before a margin write or the end.
   localparam int SETTLE_CYCLES = 64;
   // Items per random phase; six phases plus the directed part give about 310.
   localparam int PHASE_ITEMS   = 44;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mrect_req_if req_chan();
   mrect_rsp_if rsp_chan();
   mrect_csr_if csr_chan();

   merge_overlapping_rects_core #(
      .MAX_RECTS(BATCH_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   survivor_board board = new();

   // Idling controls shared between the stimulus and the result sink. When a
   // dense flag is set that side never idles; hold_request asks the sink for
   // one long stall after its next transfer.
   bit sender_dense;
   bit sink_dense;
   bit hold_request;
   int margin_writes;

   // Offers one rectangle after a random gap and waits for its transfer. The
   // valid line stays high across back-to-back items, so it is only lowered
   // when a gap is actually taken.
   task automatic send_rect(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input bit last);
      int gap;
      gap = sender_dense ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.in_x      <= x;
      req_chan.in_y      <= y;
      req_chan.in_width  <= w;
      req_chan.in_height <= h;
      req_chan.in_last   <= last;
      do @(posedge clock); while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
      board.note_rect(x, y, w, h, last);
   endtask

   // Stops offering input and waits until every predicted survivor has been
   // taken, then waits out the settle count given as its argument.
   task automatic drain(input int settle);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Margin writes only happen while the block is idle: after reset or after a drain.
   task automatic write_margin(input int m);
      csr_chan.valid        <= 1'b1;
      csr_chan.merge_margin <= m[MARGIN_W-1:0];
      do @(posedge clock); while (!(csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1));
      csr_chan.valid <= 1'b0;
      board.set_margin(m[MARGIN_W-1:0]);
      margin_writes++;
   endtask

   // One batch of random rectangles. Most are clustered around one point so
   // that joins and chains of joins are common; some are full-range noise,
   // which also brings in sizes above the image limit, and some sit at the
   // far edge with large sizes so that unions saturate.
   task automatic send_batch(input int len);
      int                 spread, cx, cy, kind;
      logic [COORD_W-1:0] x, y;
      logic [SIZE_W-1:0]  w, h;
      spread = ($urandom_range(0, 3) == 0) ? 2000 : 200;
      cx     = $urandom_range(0, 16383 - spread);
      cy     = $urandom_range(0, 16383 - spread);
      for (int k = 0; k < len; k++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            w = SIZE_W'($urandom);
            h = SIZE_W'($urandom);
         end else if (kind == 1) begin
            x = COORD_W'($urandom_range(15800, 16383));
            y = COORD_W'($urandom_range(0, 16383));
            w = SIZE_W'($urandom_range(8000, 16384));
            h = SIZE_W'($urandom_range(8000, 16384));
         end else begin
            x = COORD_W'(cx + $urandom_range(0, spread));
            y = COORD_W'(cy + $urandom_range(0, spread));
            w = SIZE_W'($urandom_range(0, spread / 2 + 20));
            h = SIZE_W'($urandom_range(0, spread / 2 + 20));
         end
         send_rect(x, y, w, h, k == len - 1);
      end
   endtask

   // A random phase under one margin setting. An overfilled batch runs more
   // rectangles than the store holds so that the excess is dropped. Now and
   // then the sender stops until every survivor has been taken.
   task automatic run_phase(input int m, input bit dense, input bit pressure,
                            input bit overfill);
      int sent, len;
      write_margin(m);
      sender_dense = dense;
      sink_dense   = dense;
      sent         = 0;
      if (pressure)
         hold_request = 1'b1;
      if (overfill) begin
         len = $urandom_range(BATCH_DEPTH + 1, BATCH_DEPTH + 4);
         send_batch(len);
         sent += len;
      end
      while (sent < PHASE_ITEMS) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         send_batch(len);
         sent += len;
         if ($urandom_range(0, 9) == 0)
            drain(1);
      end
      drain(SETTLE_CYCLES);
   endtask

   // Result sink. It draws a stall before each result and counts the long
   // hold-off itself, so the sender keeps offering items meanwhile and the
   // block has to stall its input once its result register backs up.
   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = sink_dense ? 0 : $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         board.check_survivor(rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_width,
                              rsp_chan.out_height, rsp_chan.out_last);
      end
   end

   // Main stimulus: reset, a short directed set under zero margin, then random
   // phases that walk the margin through 1024, -1024 and values in between.
   initial begin : stimulus
      req_chan.valid        = 1'b0;
      req_chan.in_x         = '0;
      req_chan.in_y         = '0;
      req_chan.in_width     = '0;
      req_chan.in_height    = '0;
      req_chan.in_last      = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.merge_margin = '0;
      sender_dense          = 1'b0;
      sink_dense            = 1'b0;
      hold_request          = 1'b0;
      margin_writes         = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_margin(0);

      // A single empty box at the origin, then a single box at the far
      // corner with the largest legal size.
      send_rect(14'd0, 14'd0, 15'd0, 15'd0, 1'b1);
      send_rect(14'd16383, 14'd16383, 15'd16384, 15'd16384, 1'b1);
      // Sizes above the image limit are clamped on entry.
      send_rect(14'd5, 14'd7, 15'd32767, 15'd16385, 1'b1);
      // Two overlapping boxes merge into their union.
      send_rect(14'd10, 14'd10, 15'd20, 15'd20, 1'b0);
      send_rect(14'd20, 14'd20, 15'd20, 15'd20, 1'b1);
      // Two disjoint boxes both survive.
      send_rect(14'd0, 14'd0, 15'd10, 15'd10, 1'b0);
      send_rect(14'd100, 14'd100, 15'd10, 15'd10, 1'b1);
      // Boxes that only touch have zero overlap and stay apart at zero margin.
      send_rect(14'd0, 14'd0, 15'd10, 15'd10, 1'b0);
      send_rect(14'd10, 14'd0, 15'd10, 15'd10, 1'b1);
      // The union width exceeds the image limit and is clamped.
      send_rect(14'd0, 14'd0, 15'd16384, 15'd100, 1'b0);
      send_rect(14'd16383, 14'd50, 15'd16384, 15'd100, 1'b1);
      // A chain: the first two only join through the grown union of the third.
      send_rect(14'd0, 14'd0, 15'd10, 15'd10, 1'b0);
      send_rect(14'd20, 14'd0, 15'd10, 15'd10, 1'b0);
      send_rect(14'd5, 14'd0, 15'd20, 15'd10, 1'b1);
      // A zero-area box inside another has zero overlap.
      send_rect(14'd50, 14'd50, 15'd0, 15'd0, 1'b0);
      send_rect(14'd40, 14'd40, 15'd20, 15'd20, 1'b1);
      drain(SETTLE_CYCLES);

      run_phase(1024, 1'b0, 1'b0, 1'b1);
      run_phase(-1024, 1'b0, 1'b0, 1'b0);
      run_phase(5, 1'b1, 1'b0, 1'b0);
      run_phase(-3, 1'b0, 1'b1, 1'b0);
      run_phase($urandom_range(0, 2048) - 1024, 1'b0, 1'b0, 1'b1);
      run_phase($urandom_range(0, 2048) - 1024, 1'b0, 1'b0, 1'b0);

      $display("Run covered %0d rectangles in %0d batches under %0d margin settings,",
               board.rects_taken, board.batches_closed, margin_writes);
      $display("with %0d survivors compared and %0d mismatches.",
               board.survivors_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("merge_overlapping_rects_core verification clean");
      end else begin
         $display("merge_overlapping_rects_core verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin : watchdog
      #1000000;
      $display("merge_overlapping_rects_core verification failed");
      $finish;
   end

endmodule

/* sim.f */
src/mrect_pkg.sv
src/mrect_ifs.sv
src/mrect_mem.sv
src/mrect_join.sv
src/merge_overlapping_rects_core.sv
sim/mrect_tb_pkg.sv
sim/merge_overlapping_rects_core_tb.sv
